// ===== rtl/dfte_pkg.sv =====
// Shared types, character codes and division constants for the date format text expander.
package dfte_pkg;

    localparam int CODE_W = 27;
    localparam int CHAR_W = 8;
    localparam int MAX_CHARS = 9;

    // Reciprocals for exact division by 100 at the operand widths used.
    localparam logic [27:0] DIV100_MUL_CODE = 28'd171798692;
    localparam logic [21:0] DIV100_MUL_Q = 22'd2684355;
    localparam logic [14:0] DIV100_MUL_Y = 15'd20972;

    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_YEAR_FULL = 8'h59;
    localparam logic [7:0] CH_YEAR_TWO = 8'h79;
    localparam logic [7:0] CH_MONTH_NAME = 8'h4D;
    localparam logic [7:0] CH_MONTH_TWO = 8'h6D;
    localparam logic [7:0] CH_DAY_ORD = 8'h44;
    localparam logic [7:0] CH_DAY_TWO = 8'h64;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ctl_t;

    typedef struct packed {
        logic       y4;
        logic [3:0] y3;
        logic [3:0] y2;
        logic [3:0] y1;
        logic [3:0] y0;
        logic [6:0] month;
        logic [3:0] mon_t;
        logic [3:0] mon_o;
        logic [3:0] day_t;
        logic [3:0] day_o;
        ctl_t       ctl;
    } digits_t;

    typedef struct packed {
        logic [3:0]           cnt;
        logic [0:8][7:0]      chars;
        logic                 char_valid;
        logic                 err;
        logic                 eos;
    } expansion_t;

    typedef struct packed {
        logic [3:0]      len;
        logic [0:8][7:0] text;
    } month_text_t;

    function automatic month_text_t month_text(input logic [3:0] month);
        month_text_t mt;
        mt = '0;
        case (month)
            4'd1: mt = '{len: 4'd7, text: {"January", 16'h0}};
            4'd2: mt = '{len: 4'd8, text: {"February", 8'h0}};
            4'd3: mt = '{len: 4'd5, text: {"March", 32'h0}};
            4'd4: mt = '{len: 4'd5, text: {"April", 32'h0}};
            4'd5: mt = '{len: 4'd3, text: {"May", 48'h0}};
            4'd6: mt = '{len: 4'd4, text: {"June", 40'h0}};
            4'd7: mt = '{len: 4'd4, text: {"July", 40'h0}};
            4'd8: mt = '{len: 4'd6, text: {"August", 24'h0}};
            4'd9: mt = '{len: 4'd9, text: "September"};
            4'd10: mt = '{len: 4'd7, text: {"October", 16'h0}};
            4'd11: mt = '{len: 4'd8, text: {"November", 8'h0}};
            4'd12: mt = '{len: 4'd8, text: {"December", 8'h0}};
            default: mt = '0;
        endcase
        return mt;
    endfunction

endpackage

// ===== rtl/date_format_text_expander.sv =====
// Top level of the date format text expander: date unpacking pipeline and character buffer.
// An accepted input beat passes through the unpack pipeline registers and is then registered
// into the character buffer, which offers its first result beat. One input beat is taken per
// cycle while each format character expands to a single result beat and m_ready is high; a
// longer expansion holds the pipeline while the buffer drains it, one character per ready cycle.
// Reset is synchronous and active low; it clears valid flags, buffer count and pending error.
module date_format_text_expander (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [26:0] s_date_code,
    input  logic [7:0]  s_format_char,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_char_valid,
    output logic        m_end_of_string,
    output logic        m_format_error
);

    logic                item_valid;
    dfte_pkg::digits_t   item;
    logic                load_ok;
    logic                pipe_en;

    assign pipe_en = load_ok || !item_valid;
    assign s_ready = pipe_en;

    dfte_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .in_code   (s_date_code),
        .in_char   (s_format_char),
        .in_last   (s_last),
        .out_valid (item_valid),
        .out_item  (item)
    );

    dfte_expand u_expand (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item            (item),
        .load_ok         (load_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_char_valid    (m_char_valid),
        .m_end_of_string (m_end_of_string),
        .m_format_error  (m_format_error)
    );

endmodule

// ===== rtl/dfte_unpack.sv =====
// Pipeline that splits the packed date code into year, month and day decimal digits.
module dfte_unpack (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [26:0]           in_code,
    input  logic [7:0]            in_char,
    input  logic                  in_last,
    output logic                  out_valid,
    output dfte_pkg::digits_t     out_item
);

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } pair_t;

    function automatic pair_t split10(input logic [6:0] v);
        logic [14:0] p;
        logic [6:0]  tx10;
        logic [6:0]  r;
        pair_t       res;
        p = {8'b0, v} * 15'd205;
        res.tens = p[14:11];
        tx10 = {3'b0, res.tens} * 7'd10;
        r = v - tx10;
        res.ones = r[3:0];
        return res;
    endfunction

    logic [5:0]          v_reg;
    dfte_pkg::ctl_t      ctl_reg [0:4];

    logic [26:0]         code0_reg;
    logic [20:0]         q1_reg;
    logic [6:0]          codelo1_reg;
    logic [13:0]         year2_reg;
    logic [6:0]          day2_reg;
    logic [6:0]          q1lo2_reg;
    logic [7:0]          yh3_reg;
    logic [6:0]          ylo3_reg;
    logic [6:0]          mon3_reg;
    logic [6:0]          day3_reg;
    logic                y4_4_reg;
    logic [6:0]          yhr4_reg;
    logic [6:0]          yl4_reg;
    logic [6:0]          mon4_reg;
    logic [6:0]          day4_reg;
    dfte_pkg::digits_t   item5_reg;

    logic [54:0]         prod1;
    logic [13:0]         q1lo_x100;
    logic [42:0]         prod2;
    logic [13:0]         yr_x100;
    logic [28:0]         prod3;
    logic [13:0]         yh_x100;
    logic                yh_hund;
    pair_t               yhr_p;
    pair_t               yl_p;
    pair_t               mon_p;
    pair_t               day_p;

    assign prod1 = {28'b0, code0_reg} * {27'b0, dfte_pkg::DIV100_MUL_CODE};
    assign q1lo_x100 = {7'b0, q1_reg[6:0]} * 14'd100;
    assign prod2 = {22'b0, q1_reg} * {21'b0, dfte_pkg::DIV100_MUL_Q};
    assign yr_x100 = {7'b0, year2_reg[6:0]} * 14'd100;
    assign prod3 = {15'b0, year2_reg} * {14'b0, dfte_pkg::DIV100_MUL_Y};
    assign yh_x100 = {7'b0, yh3_reg[6:0]} * 14'd100;
    assign yh_hund = (yh3_reg >= 8'd100);
    assign yhr_p = split10(yhr4_reg);
    assign yl_p = split10(yl4_reg);
    assign mon_p = split10(mon4_reg);
    assign day_p = split10(day4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= '{ch: in_char, last: in_last};
            for (int i = 1; i < 5; i++) begin
                ctl_reg[i] <= ctl_reg[i - 1];
            end
            code0_reg <= in_code;

            q1_reg <= prod1[54:34];
            codelo1_reg <= code0_reg[6:0];

            year2_reg <= prod2[41:28];
            day2_reg <= codelo1_reg - q1lo_x100[6:0];
            q1lo2_reg <= q1_reg[6:0];

            yh3_reg <= prod3[28:21];
            ylo3_reg <= year2_reg[6:0];
            mon3_reg <= q1lo2_reg - yr_x100[6:0];
            day3_reg <= day2_reg;

            y4_4_reg <= yh_hund;
            yhr4_reg <= yh_hund ? 7'(yh3_reg - 8'd100) : yh3_reg[6:0];
            yl4_reg <= ylo3_reg - yh_x100[6:0];
            mon4_reg <= mon3_reg;
            day4_reg <= day3_reg;

            item5_reg.y4 <= y4_4_reg;
            item5_reg.y3 <= yhr_p.tens;
            item5_reg.y2 <= yhr_p.ones;
            item5_reg.y1 <= yl_p.tens;
            item5_reg.y0 <= yl_p.ones;
            item5_reg.month <= mon4_reg;
            item5_reg.mon_t <= mon_p.tens;
            item5_reg.mon_o <= mon_p.ones;
            item5_reg.day_t <= day_p.tens;
            item5_reg.day_o <= day_p.ones;
            item5_reg.ctl <= ctl_reg[4];
        end
    end

    assign out_valid = v_reg[5];
    assign out_item = item5_reg;

endmodule

// ===== rtl/dfte_expand.sv =====
// Expansion of one format character into a character buffer that drains one beat per cycle while m_ready is high.
module dfte_expand (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  dfte_pkg::digits_t   item,
    output logic                load_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_char,
    output logic                m_char_valid,
    output logic                m_end_of_string,
    output logic                m_format_error
);

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        return dfte_pkg::CH_ZERO + {4'b0, d};
    endfunction

    function automatic logic [0:1][7:0] ord_suffix(input logic [3:0] t, input logic [3:0] o);
        logic [0:1][7:0] s;
        s = "th";
        if (t != 4'd1) begin
            case (o)
                4'd1: s = "st";
                4'd2: s = "nd";
                4'd3: s = "rd";
                default: s = "th";
            endcase
        end
        return s;
    endfunction

    logic [0:8][7:0]          chars_reg;
    logic [3:0]               rem_reg;
    logic                     cv_reg;
    logic                     err_reg;
    logic                     eos_reg;
    logic                     err_seen_reg;
    logic                     err_seen_next;

    dfte_pkg::expansion_t     exp;
    dfte_pkg::month_text_t    mt;
    logic [0:4][3:0]          ydig;
    logic [0:4][3:0]          ysh;
    logic [2:0]               ylen;
    logic [2:0]               yskip;
    logic [0:1][7:0]          suf;
    logic                     load;

    assign mt = dfte_pkg::month_text(item.month[3:0]);
    assign ydig = {3'b0, item.y4, item.y3, item.y2, item.y1, item.y0};
    assign yskip = 3'd5 - ylen;
    assign ysh = ydig << {yskip, 2'b00};
    assign suf = ord_suffix(item.day_t, item.day_o);

    always_comb begin
        if (item.y4) begin
            ylen = 3'd5;
        end else if (item.y3 != 4'd0) begin
            ylen = 3'd4;
        end else if (item.y2 != 4'd0) begin
            ylen = 3'd3;
        end else if (item.y1 != 4'd0) begin
            ylen = 3'd2;
        end else begin
            ylen = 3'd1;
        end
    end

    always_comb begin
        exp = '0;
        exp.char_valid = 1'b1;
        err_seen_next = err_seen_reg;
        if (err_seen_reg) begin
            exp.char_valid = 1'b0;
            if (item.ctl.last) begin
                exp.cnt = 4'd1;
                exp.err = 1'b1;
                exp.eos = 1'b1;
                err_seen_next = 1'b0;
            end
        end else begin
            if (item.ctl.ch >= dfte_pkg::CH_UPPER_A && item.ctl.ch <= dfte_pkg::CH_LOWER_Z) begin
                unique case (item.ctl.ch)
                    dfte_pkg::CH_YEAR_FULL: begin
                        for (int i = 0; i < 5; i++) begin
                            if (3'(i) < ylen) begin
                                exp.chars[i] = to_ascii(ysh[i]);
                            end
                        end
                        exp.cnt = {1'b0, ylen};
                    end
                    dfte_pkg::CH_YEAR_TWO: begin
                        exp.chars[0] = to_ascii(item.y1);
                        exp.chars[1] = to_ascii(item.y0);
                        exp.cnt = 4'd2;
                    end
                    dfte_pkg::CH_MONTH_NAME: begin
                        if (item.month >= 7'd1 && item.month <= 7'd12) begin
                            exp.chars = mt.text;
                            exp.cnt = mt.len;
                        end else begin
                            exp.cnt = 4'd1;
                            exp.char_valid = 1'b0;
                            exp.err = 1'b1;
                            err_seen_next = !item.ctl.last;
                        end
                    end
                    dfte_pkg::CH_MONTH_TWO: begin
                        exp.chars[0] = to_ascii(item.mon_t);
                        exp.chars[1] = to_ascii(item.mon_o);
                        exp.cnt = 4'd2;
                    end
                    dfte_pkg::CH_DAY_ORD: begin
                        if (item.day_t != 4'd0) begin
                            exp.chars[0] = to_ascii(item.day_t);
                            exp.chars[1] = to_ascii(item.day_o);
                            exp.chars[2] = suf[0];
                            exp.chars[3] = suf[1];
                            exp.cnt = 4'd4;
                        end else begin
                            exp.chars[0] = to_ascii(item.day_o);
                            exp.chars[1] = suf[0];
                            exp.chars[2] = suf[1];
                            exp.cnt = 4'd3;
                        end
                    end
                    dfte_pkg::CH_DAY_TWO: begin
                        exp.chars[0] = to_ascii(item.day_t);
                        exp.chars[1] = to_ascii(item.day_o);
                        exp.cnt = 4'd2;
                    end
                    default: begin
                        exp.chars[0] = item.ctl.ch;
                        exp.cnt = 4'd1;
                    end
                endcase
            end else if (item.ctl.ch != dfte_pkg::CH_PERCENT) begin
                exp.chars[0] = item.ctl.ch;
                exp.cnt = 4'd1;
            end
            if (item.ctl.last) begin
                if (exp.cnt == 4'd0) begin
                    exp.cnt = 4'd1;
                    exp.char_valid = 1'b0;
                end
                exp.eos = 1'b1;
            end
        end
    end

    assign load_ok = (rem_reg == 4'd0) || (rem_reg == 4'd1 && m_ready);
    assign load = item_valid && load_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            err_seen_reg <= 1'b0;
        end else if (load) begin
            rem_reg <= exp.cnt;
            err_seen_reg <= err_seen_next;
        end else if (m_valid && m_ready) begin
            rem_reg <= rem_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chars_reg <= exp.chars;
            cv_reg <= exp.char_valid;
            err_reg <= exp.err;
            eos_reg <= exp.eos;
        end else if (m_valid && m_ready) begin
            chars_reg <= chars_reg << 8;
        end
    end

    assign m_valid = (rem_reg != 4'd0);
    assign m_out_char = chars_reg[0];
    assign m_char_valid = cv_reg;
    assign m_format_error = err_reg;
    assign m_end_of_string = eos_reg && (rem_reg == 4'd1);

endmodule

// ===== rtl/dfte_checker.sv =====
// Port-level checks on the date format text expander, bound to its top level.
module dfte_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [26:0] s_date_code,
    input logic [7:0]  s_format_char,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_char,
    input logic        m_char_valid,
    input logic        m_end_of_string,
    input logic        m_format_error
);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge aclk)
        aresetn && m_valid && !m_ready |=> !aresetn || (m_valid && $stable(m_out_char)
            && $stable(m_char_valid) && $stable(m_end_of_string) && $stable(m_format_error)))
        else $error("result beat changed while stalled");

    // A marker beat carries a zero byte.
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> m_out_char == 8'd0)
        else $error("marker beat with nonzero byte");

    // An error beat is always a marker.
    a_err_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_format_error |-> !m_char_valid)
        else $error("error beat carries a character");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat offered right after reset");

endmodule

bind date_format_text_expander dfte_checker u_dfte_checker (.*);
